### src/mpk_pkg.sv
// Package for the MessagePack stream tokenizer: token kinds, parse phases
// and the request/command types shared by front and back. No dependencies.
`default_nettype none
package mpk_pkg;
   typedef enum logic [3:0] {
      KIND_NIL = 4'd0, KIND_BOOL = 4'd1, KIND_UINT = 4'd2, KIND_INT = 4'd3,
      KIND_F32 = 4'd4, KIND_F64 = 4'd5, KIND_STRH = 4'd6, KIND_STRB = 4'd7,
      KIND_BINH = 4'd8, KIND_BINB = 4'd9, KIND_ARR = 4'd10, KIND_MAP = 4'd11,
      KIND_UNSUP = 4'd12, KIND_OVF = 4'd13
   } kind_type;

   typedef enum logic [1:0] {
      PH_TYPE = 2'd0, PH_FIELD = 2'd1, PH_PAYLOAD = 2'd2
   } phase_type;

   // operation of a classified token for the back part
   typedef enum logic [1:0] {
      OP_FINISH = 2'd0,  // value done: pop closed levels
      OP_PLAIN  = 2'd1,  // token with no nesting effect
      OP_PUSH   = 2'd2,  // nonempty container header
      OP_ERROR  = 2'd3   // unsupported code, sticks
   } op_type;

   typedef struct packed {
      op_type     op;
      kind_type   kind;
      logic [63:0] value;
      logic [31:0] count;
      logic        pair;   // map: element count doubles
   } cmd_type;

   function automatic logic [3:0] field_len(input logic [7:0] c);
      case (c)
         8'hd9, 8'hc4, 8'hd0, 8'hcc: field_len = 4'd1;
         8'hda, 8'hc5, 8'hd1, 8'hcd, 8'hdc, 8'hde: field_len = 4'd2;
         8'hdb, 8'hc6, 8'hd2, 8'hce, 8'hdd, 8'hdf, 8'hca: field_len = 4'd4;
         8'hd3, 8'hcf, 8'hcb: field_len = 4'd8;
         default: field_len = 4'd0;
      endcase
   endfunction
endpackage
`default_nettype wire

### src/mpk_front.sv
// Front part: accepts stream bytes, gathers field bytes and classifies
// tokens into commands. Depends on mpk_pkg.
`default_nettype none
module mpk_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [7:0]       in_byte,
   output logic                  cmd_valid,
   input  wire logic             cmd_ready,
   output mpk_pkg::cmd_type      cmd
);
   mpk_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  code_ff, code_in;
   logic [3:0]  left_ff, left_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] pay_ff, pay_in;
   logic [63:0] v;
   logic [31:0] n;
   logic        fire;

   assign in_ready = cmd_ready;
   assign fire = in_valid && in_ready;

   always_comb begin
      phase_in = phase_ff;
      code_in = code_ff;
      left_in = left_ff;
      acc_in = acc_ff;
      pay_in = pay_ff;
      cmd_valid = 1'b0;
      cmd = '0;
      cmd.op = mpk_pkg::OP_FINISH;
      v = {acc_ff[55:0], in_byte};
      n = v[31:0];
      case (phase_ff)
         mpk_pkg::PH_FIELD: begin
            acc_in = v;
            left_in = left_ff - 4'd1;
            if (left_ff <= 4'd1) begin
               cmd_valid = fire;
               phase_in = mpk_pkg::PH_TYPE;
               if (code_ff inside {[8'hd9:8'hdb], [8'hc4:8'hc6]}) begin
                  cmd.kind = (code_ff >= 8'hd9) ? mpk_pkg::KIND_STRH : mpk_pkg::KIND_BINH;
                  cmd.count = n;
                  if (n != 32'd0) begin
                     cmd.op = mpk_pkg::OP_PLAIN;
                     phase_in = mpk_pkg::PH_PAYLOAD;
                     pay_in = n;
                  end
               end else if (code_ff inside {[8'hd0:8'hd3]}) begin
                  cmd.kind = mpk_pkg::KIND_INT;
                  case (code_ff)
                     8'hd0: cmd.value = {{56{v[7]}}, v[7:0]};
                     8'hd1: cmd.value = {{48{v[15]}}, v[15:0]};
                     8'hd2: cmd.value = {{32{v[31]}}, v[31:0]};
                     default: cmd.value = v;
                  endcase
               end else if (code_ff inside {[8'hcc:8'hcf]}) begin
                  cmd.kind = mpk_pkg::KIND_UINT;
                  cmd.value = v;
               end else if (code_ff == 8'hca) begin
                  cmd.kind = mpk_pkg::KIND_F32;
                  cmd.value = {32'd0, v[31:0]};
               end else if (code_ff == 8'hcb) begin
                  cmd.kind = mpk_pkg::KIND_F64;
                  cmd.value = v;
               end else begin
                  cmd.kind = (code_ff inside {8'hdc, 8'hdd}) ? mpk_pkg::KIND_ARR
                                                             : mpk_pkg::KIND_MAP;
                  cmd.pair = !(code_ff inside {8'hdc, 8'hdd});
                  cmd.count = n;
                  if (n != 32'd0) cmd.op = mpk_pkg::OP_PUSH;
               end
            end
         end
         mpk_pkg::PH_PAYLOAD: begin
            cmd_valid = fire;
            cmd.kind = (code_ff inside {[8'hc4:8'hc6]}) ? mpk_pkg::KIND_BINB
                                                        : mpk_pkg::KIND_STRB;
            cmd.value = {56'd0, in_byte};
            pay_in = pay_ff - 32'd1;
            if (pay_ff > 32'd1) cmd.op = mpk_pkg::OP_PLAIN;
            else phase_in = mpk_pkg::PH_TYPE;
         end
         default: begin
            cmd_valid = fire;
            if (in_byte <= 8'h7f) begin
               cmd.kind = mpk_pkg::KIND_UINT;
               cmd.value = {56'd0, in_byte};
            end else if (in_byte >= 8'he0) begin
               cmd.kind = mpk_pkg::KIND_INT;
               cmd.value = {56'hff_ffff_ffff_ffff, in_byte};
            end else if (in_byte <= 8'h9f) begin
               cmd.kind = (in_byte <= 8'h8f) ? mpk_pkg::KIND_MAP : mpk_pkg::KIND_ARR;
               cmd.pair = (in_byte <= 8'h8f);
               cmd.count = {28'd0, in_byte[3:0]};
               if (in_byte[3:0] != 4'd0) cmd.op = mpk_pkg::OP_PUSH;
            end else if (in_byte <= 8'hbf) begin
               cmd.kind = mpk_pkg::KIND_STRH;
               cmd.count = {27'd0, in_byte[4:0]};
               code_in = in_byte;
               if (in_byte[4:0] != 5'd0) begin
                  cmd.op = mpk_pkg::OP_PLAIN;
                  phase_in = mpk_pkg::PH_PAYLOAD;
                  pay_in = {27'd0, in_byte[4:0]};
               end
            end else if (in_byte == 8'hc0) begin
               cmd.kind = mpk_pkg::KIND_NIL;
            end else if (in_byte inside {8'hc2, 8'hc3}) begin
               cmd.kind = mpk_pkg::KIND_BOOL;
               cmd.value = {63'd0, in_byte[0]};
            end else if (mpk_pkg::field_len(in_byte) != 4'd0) begin
               cmd_valid = 1'b0;
               code_in = in_byte;
               left_in = mpk_pkg::field_len(in_byte);
               acc_in = '0;
               phase_in = mpk_pkg::PH_FIELD;
            end else begin
               cmd.op = mpk_pkg::OP_ERROR;
               cmd.kind = mpk_pkg::KIND_UNSUP;
               cmd.value = {56'd0, in_byte};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mpk_pkg::PH_TYPE;
         code_ff <= '0;
         left_ff <= '0;
         acc_ff <= '0;
         pay_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         code_ff <= code_in;
         left_ff <= left_in;
         acc_ff <= acc_in;
         pay_ff <= pay_in;
      end
   end
endmodule
`default_nettype wire

### src/mpk_queue.sv
// Two-entry command queue between front and back parts.
// Depends on mpk_pkg.
`default_nettype none
module mpk_queue (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         wr_valid,
   output logic              wr_ready,
   input  wire mpk_pkg::cmd_type wr_data,
   output logic              rd_valid,
   input  wire logic         rd_ready,
   output mpk_pkg::cmd_type  rd_data
);
   mpk_pkg::cmd_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       wr, rd;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= !wp_ff;
         if (rd) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
   end
endmodule
`default_nettype wire

### src/mpk_back.sv
// Back part: owns the nesting count stack and the sticky error, and
// pops closed levels one at a time via a registered stack-top read. Depends on mpk_pkg.
`default_nettype none
module mpk_back #(
   parameter int MAX_DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   output logic                  cmd_ready,
   input  wire mpk_pkg::cmd_type cmd,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [111:0]          out_data,
   output logic                  stuck
);
   localparam int LW = $clog2(MAX_DEPTH + 1);
   localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   logic [32:0]  stack_ff [MAX_DEPTH];
   logic [LW-1:0] level_ff;
   logic          err_ff;
   logic          busy_ff;      // popping levels of a finished value
   logic [4:0]    closed_ff;
   logic          ov_ff;        // output register full
   logic [3:0]    kind_ff;
   logic [63:0]   value_ff;
   logic [31:0]   count_ff;
   logic          comp_ff, done_ff;
   logic [32:0]   top_ff;       // registered read of stack top
   logic          top_ok_ff;
   logic [32:0]   left;
   logic          take, out_free;
   logic [AW-1:0] top_idx;

   assign out_free = !ov_ff || out_ready;
   assign cmd_ready = !busy_ff && !top_ok_ff && out_free;
   assign take = cmd_valid && cmd_ready;
   assign out_valid = ov_ff;
   assign stuck = err_ff;
   assign out_data = {5'd0, done_ff, closed_ff, comp_ff, count_ff, value_ff, kind_ff};
   assign left = top_ff - 33'd1;
   assign top_idx = AW'(level_ff - LW'(1));

   always_ff @(posedge clock) begin
      if (take && cmd.op == mpk_pkg::OP_PUSH && !err_ff && level_ff < LW'(MAX_DEPTH))
         stack_ff[AW'(level_ff)] <= cmd.pair ? {cmd.count, 1'b0} : {1'b0, cmd.count};
      else if (busy_ff && top_ok_ff && left != 33'd0)
         stack_ff[top_idx] <= left;
      top_ff <= stack_ff[top_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         err_ff <= 1'b0;
         busy_ff <= 1'b0;
         top_ok_ff <= 1'b0;
         ov_ff <= 1'b0;
         closed_ff <= '0;
      end else begin
         if (ov_ff && out_ready) ov_ff <= 1'b0;
         if (busy_ff) begin
            if (level_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               ov_ff <= 1'b1;
            end else if (!top_ok_ff) begin
               top_ok_ff <= 1'b1;   // wait for registered top read
            end else begin
               top_ok_ff <= 1'b0;
               if (left == 33'd0) begin
                  level_ff <= level_ff - LW'(1);
                  closed_ff <= closed_ff + 5'd1;
               end else begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b0;
                  ov_ff <= 1'b1;
               end
            end
         end else if (take && !err_ff) begin
            kind_ff <= cmd.kind;
            value_ff <= cmd.value;
            count_ff <= cmd.count;
            comp_ff <= 1'b0;
            done_ff <= 1'b0;
            closed_ff <= '0;
            case (cmd.op)
               mpk_pkg::OP_FINISH: begin
                  comp_ff <= 1'b1;
                  busy_ff <= 1'b1;
               end
               mpk_pkg::OP_PUSH: begin
                  ov_ff <= 1'b1;
                  if (level_ff >= LW'(MAX_DEPTH)) begin
                     kind_ff <= mpk_pkg::KIND_OVF;
                     err_ff <= 1'b1;
                  end else level_ff <= level_ff + LW'(1);
               end
               mpk_pkg::OP_ERROR: begin
                  ov_ff <= 1'b1;
                  err_ff <= 1'b1;
               end
               default: ov_ff <= 1'b1;
            endcase
         end
      end
   end
endmodule
`default_nettype wire

### src/msgpack_stream_tokenizer.sv
// Top level of the MessagePack stream tokenizer: front, command queue and
// back. Depends on mpk_pkg, mpk_front, mpk_queue and mpk_back.
//
// One request is one stream byte. Type, field and payload bytes are taken
// while the queue has room; a byte that finishes a value then has the back
// part examine the stack levels one at a time (closed levels plus the one
// left open), each through a registered read of the stack top, as the count
// stack is a memory with a registered read port, before its result is
// offered. After an unsupported code or a stack overflow, bytes are
// consumed with no result until reset.
`default_nettype none
module msgpack_stream_tokenizer #(
   parameter int MAX_DEPTH = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    req_tdata,   // data_byte
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // kind[3:0], value[67:4], count[99:68], completes[100],
   // closed_levels[105:101], message_done[106], zero fill to 111
   output logic [111:0]       rsp_tdata
);
   mpk_pkg::cmd_type f_cmd, q_cmd;
   logic f_valid, f_ready, q_valid, q_ready, stuck;
   logic fr_ready;

   // once stuck, drain every byte without results
   assign req_tready = stuck ? 1'b1 : fr_ready;

   mpk_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid && !stuck), .in_ready(fr_ready), .in_byte(req_tdata),
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
   );

   mpk_queue u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
   );

   mpk_back #(.MAX_DEPTH(MAX_DEPTH)) u_back (
      .clock, .reset,
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(rsp_tdata),
      .stuck
   );

   a_stuck_holds: assert property (@(posedge clock) disable iff (reset)
      stuck |=> stuck) else $error("sticky error cleared");
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[111:107] == 5'd0) else $error("pad bits set");
   a_done_completes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[106] |-> rsp_tdata[100]) else $error("done without completes");
endmodule
`default_nettype wire

### tb/mpk_token_checker.sv
// Token checker for the MessagePack stream tokenizer: watches both channels,
// predicts each token from the accepted bytes and compares. Depends on mpk_pkg.
`default_nettype none
module mpk_token_checker
   import mpk_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [7:0]   req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [111:0] rsp_tdata,
   output int                fail_count,
   output int                tokens_pending
);
   localparam int STACK_DEPTH = 16;

   typedef struct {
      kind_type    kind;
      logic [63:0] value;
      logic [31:0] count;
      logic        completes;
      logic [4:0]  closed;
      logic        done;
   } token_t;

   token_t      expected_tokens[$];
   phase_type   phase;
   logic [7:0]  code;
   logic [3:0]  field_left;
   logic [63:0] field_acc;
   logic [31:0] payload_left;
   logic [32:0] level_counts[STACK_DEPTH];
   int          level;
   bit          stuck;

   initial fail_count = 0;
   assign tokens_pending = expected_tokens.size();

   function automatic token_t make_token(kind_type k, logic [63:0] v, logic [31:0] n);
      token_t t;
      t.kind = k;
      t.value = v;
      t.count = n;
      t.completes = 1'b0;
      t.closed = 5'd0;
      t.done = 1'b0;
      return t;
   endfunction

   // Field bytes that follow a type byte, 0 where none follow.
   function automatic int field_bytes(logic [7:0] c);
      if (c >= 8'hc4 && c <= 8'hc6) return 1 << (c - 8'hc4);
      if (c >= 8'hcc && c <= 8'hcf) return 1 << (c - 8'hcc);
      if (c >= 8'hd0 && c <= 8'hd3) return 1 << (c - 8'hd0);
      if (c >= 8'hd9 && c <= 8'hdb) return 1 << (c - 8'hd9);
      if (c == 8'hca) return 4;
      if (c == 8'hcb) return 8;
      if (c == 8'hdc || c == 8'hde) return 2;
      if (c == 8'hdd || c == 8'hdf) return 4;
      return 0;
   endfunction

   // A value has finished: count it off and close every level it fills.
   task automatic finish_value(inout token_t t);
      int          closed;
      logic [32:0] left;
      closed = 0;
      while (level > 0) begin
         left = level_counts[level-1] - 33'd1;
         if (left == 33'd0) begin
            level--;
            closed++;
         end else begin
            level_counts[level-1] = left;
            break;
         end
      end
      t.completes = 1'b1;
      t.closed = closed[4:0];
      t.done = (level == 0);
   endtask

   task automatic open_container(inout token_t t, input kind_type k,
                                 input logic [31:0] n, input bit pair);
      if (n == 0) begin
         t = make_token(k, 64'd0, 32'd0);
         finish_value(t);
      end else if (level >= STACK_DEPTH) begin
         t = make_token(KIND_OVF, 64'd0, n);
         stuck = 1'b1;
      end else begin
         t = make_token(k, 64'd0, n);
         level_counts[level] = pair ? {n, 1'b0} : {1'b0, n};
         level++;
      end
   endtask

   task automatic open_blob(inout token_t t, input logic [7:0] c,
                            input kind_type k, input logic [31:0] n);
      t = make_token(k, 64'd0, n);
      code = c;
      if (n == 0) begin
         phase = PH_TYPE;
         finish_value(t);
      end else begin
         phase = PH_PAYLOAD;
         payload_left = n;
      end
   endtask

   task automatic close_field(inout token_t t);
      logic [63:0] v;
      logic [31:0] n;
      v = field_acc;
      n = v[31:0];
      phase = PH_TYPE;
      if (code >= 8'hd9 && code <= 8'hdb) begin
         open_blob(t, code, KIND_STRH, n);
      end else if (code >= 8'hc4 && code <= 8'hc6) begin
         open_blob(t, code, KIND_BINH, n);
      end else if (code >= 8'hd0 && code <= 8'hd3) begin
         case (code)
            8'hd0: v = {{56{v[7]}}, v[7:0]};
            8'hd1: v = {{48{v[15]}}, v[15:0]};
            8'hd2: v = {{32{v[31]}}, v[31:0]};
            default: ;
         endcase
         t = make_token(KIND_INT, v, 32'd0);
         finish_value(t);
      end else if (code >= 8'hcc && code <= 8'hcf) begin
         t = make_token(KIND_UINT, v, 32'd0);
         finish_value(t);
      end else if (code == 8'hca) begin
         t = make_token(KIND_F32, {32'd0, v[31:0]}, 32'd0);
         finish_value(t);
      end else if (code == 8'hcb) begin
         t = make_token(KIND_F64, v, 32'd0);
         finish_value(t);
      end else if (code == 8'hdc || code == 8'hdd) begin
         open_container(t, KIND_ARR, n, 1'b0);
      end else begin
         open_container(t, KIND_MAP, n, 1'b1);
      end
   endtask

   // Work out the token, if any, that one stream byte gives.
   task automatic tokenize_byte(input logic [7:0] b);
      token_t t;
      bit     has;
      has = 1'b0;
      if (stuck) return;
      if (phase == PH_FIELD) begin
         field_acc = {field_acc[55:0], b};
         if (field_left > 0) field_left--;
         if (field_left == 0) begin
            close_field(t);
            has = 1'b1;
         end
      end else if (phase == PH_PAYLOAD) begin
         t = make_token((code >= 8'hc4 && code <= 8'hc6) ? KIND_BINB : KIND_STRB,
                        {56'd0, b}, 32'd0);
         if (payload_left > 0) payload_left--;
         if (payload_left == 0) begin
            phase = PH_TYPE;
            finish_value(t);
         end
         has = 1'b1;
      end else begin
         has = 1'b1;
         if (b <= 8'h7f) begin
            t = make_token(KIND_UINT, {56'd0, b}, 32'd0);
            finish_value(t);
         end else if (b >= 8'he0) begin
            t = make_token(KIND_INT, {56'hffffffffffffff, b}, 32'd0);
            finish_value(t);
         end else if (b <= 8'h8f) begin
            open_container(t, KIND_MAP, {28'd0, b[3:0]}, 1'b1);
         end else if (b <= 8'h9f) begin
            open_container(t, KIND_ARR, {28'd0, b[3:0]}, 1'b0);
         end else if (b <= 8'hbf) begin
            open_blob(t, b, KIND_STRH, {27'd0, b[4:0]});
         end else if (b == 8'hc0) begin
            t = make_token(KIND_NIL, 64'd0, 32'd0);
            finish_value(t);
         end else if (b == 8'hc2 || b == 8'hc3) begin
            t = make_token(KIND_BOOL, {63'd0, b[0]}, 32'd0);
            finish_value(t);
         end else if (field_bytes(b) != 0) begin
            code = b;
            field_left = 4'(field_bytes(b));
            field_acc = 64'd0;
            phase = PH_FIELD;
            has = 1'b0;
         end else begin
            t = make_token(KIND_UNSUP, {56'd0, b}, 32'd0);
            stuck = 1'b1;
         end
      end
      if (has) expected_tokens.insert(expected_tokens.size(), t);
   endtask

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic compare_token(input logic [111:0] d);
      token_t w;
      if (expected_tokens.size() == 0) begin
         report("unexpected token, kind", d[3:0], 0);
         return;
      end
      w = expected_tokens.pop_front();
      if (d[3:0] != w.kind) report("kind", d[3:0], w.kind);
      if (d[67:4] != w.value) report("value", d[67:4], w.value);
      if (d[99:68] != w.count) report("count", d[99:68], w.count);
      if (d[100] != w.completes) report("completes", d[100], w.completes);
      if (d[105:101] != w.closed) report("closed_levels", d[105:101], w.closed);
      if (d[106] != w.done) report("message_done", d[106], w.done);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase = PH_TYPE;
         code = 8'd0;
         field_left = 4'd0;
         field_acc = 64'd0;
         payload_left = 32'd0;
         level = 0;
         stuck = 1'b0;
         expected_tokens.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) compare_token(rsp_tdata);
         if (req_tvalid && req_tready) tokenize_byte(req_tdata);
      end
   end
endmodule
`default_nettype wire

### tb/msgpack_stream_tokenizer_tb.sv
// Testbench top for the MessagePack stream tokenizer: builds byte streams,
// drives both channels and gives the verdict. Depends on mpk_pkg,
// msgpack_stream_tokenizer and mpk_token_checker.
`default_nettype none
module msgpack_stream_tokenizer_tb;
   import mpk_pkg::*;

   // type bytes used by name in the stimulus
   localparam logic [7:0] T_NIL = 8'hc0, T_FALSE = 8'hc2, T_TRUE = 8'hc3;
   localparam logic [7:0] T_BIN8 = 8'hc4, T_F32 = 8'hca, T_F64 = 8'hcb;
   localparam logic [7:0] T_UINT8 = 8'hcc, T_INT8 = 8'hd0, T_STR8 = 8'hd9;
   localparam logic [7:0] T_ARR16 = 8'hdc, T_ARR32 = 8'hdd, T_MAP16 = 8'hde;
   localparam logic [7:0] T_MAP32 = 8'hdf, T_FIXARR = 8'h90, T_FIXMAP = 8'h80;
   localparam logic [7:0] T_FIXSTR = 8'ha0, T_NEGFIX = 8'he0;
   localparam int BYTES_PER_PHASE = 290;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'd0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;
   int           fail_count;
   int           tokens_pending;

   int           send_idle;     // percent of cycles the sender holds back
   int           recv_idle;     // percent of cycles the receiver holds back
   bit           hold_request = 1'b0;
   logic [7:0]   stream_q[$];

   always #5 clock = ~clock;

   msgpack_stream_tokenizer u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   mpk_token_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .tokens_pending(tokens_pending)
   );

   // Receiver: stall at random, or hold off for a long stretch on request so
   // that the block fills up and pushes back on its input.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
         end
      end
   end

   task automatic push_be(input logic [63:0] v, input int n);
      for (int i = n - 1; i >= 0; i--) stream_q = {stream_q, v[8*i +: 8]};
   endtask

   task automatic push_payload(input int n);
      for (int i = 0; i < n; i++) stream_q = {stream_q, 8'($urandom)};
   endtask

   // Append one well-formed value with random content; nesting stays under
   // the stack limit, and deep levels lean towards scalars.
   task automatic build_value(input int depth);
      int          sel;
      int          n;
      int          w;
      logic [63:0] r;
      r = {$urandom, $urandom};
      sel = $urandom_range(0, 15);
      if (depth >= 15 || (depth >= 3 && $urandom_range(0, 2) != 0))
         sel = $urandom_range(0, 10);
      case (sel)
         0: stream_q = {stream_q, {1'b0, r[6:0]}};
         1: stream_q = {stream_q, {3'b111, r[4:0]}};
         2: stream_q = {stream_q, T_NIL};
         3: stream_q = {stream_q, (r[0] ? T_TRUE : T_FALSE)};
         4, 5: begin
            n = $urandom_range(0, 3);
            stream_q = {stream_q, (((sel == 4) ? T_UINT8 : T_INT8) + 8'(n))};
            push_be(r, 1 << n);
         end
         6: begin
            stream_q = {stream_q, T_F32};
            push_be(r, 4);
         end
         7: begin
            stream_q = {stream_q, T_F64};
            push_be(r, 8);
         end
         8: begin
            n = ($urandom_range(0, 7) == 0) ? 31 : $urandom_range(0, 5);
            stream_q = {stream_q, (T_FIXSTR | 8'(n))};
            push_payload(n);
         end
         9, 10: begin
            n = $urandom_range(0, 6);
            w = $urandom_range(0, 2);
            stream_q = {stream_q, (((sel == 9) ? T_STR8 : T_BIN8) + 8'(w))};
            push_be(64'(n), 1 << w);
            push_payload(n);
         end
         11: begin
            n = $urandom_range(1, 3);
            stream_q = {stream_q, (T_FIXARR | 8'(n))};
            repeat (n) build_value(depth + 1);
         end
         12: begin
            n = $urandom_range(1, 3);
            w = $urandom_range(0, 1);
            stream_q = {stream_q, (T_ARR16 + 8'(w))};
            push_be(64'(n), 2 << w);
            repeat (n) build_value(depth + 1);
         end
         13: begin
            n = $urandom_range(1, 2);
            stream_q = {stream_q, (T_FIXMAP | 8'(n))};
            repeat (2 * n) build_value(depth + 1);
         end
         14: begin
            n = $urandom_range(1, 2);
            w = $urandom_range(0, 1);
            stream_q = {stream_q, (T_MAP16 + 8'(2 * w))};
            push_be(64'(n), 2 << w);
            repeat (2 * n) build_value(depth + 1);
         end
         default: begin
            case ($urandom_range(0, 4))
               0: stream_q = {stream_q, T_FIXARR};
               1: stream_q = {stream_q, T_FIXMAP};
               2: stream_q = {stream_q, T_FIXSTR};
               3: begin
                  stream_q = {stream_q, T_BIN8, 8'd0};
               end
               default: begin
                  stream_q = {stream_q, T_MAP16};
                  push_be(64'd0, 2);
               end
            endcase
         end
      endcase
   endtask

   // Offer one byte; called at a falling edge, returns at the falling edge
   // after the request was taken with valid still high.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_stream();
      while (stream_q.size() != 0) send_byte(stream_q.pop_front());
   endtask

   // directed values: field extremes, every non-error kind and the special cases
   task automatic build_directed();
      stream_q = {8'h00, 8'h7f, 8'he0, 8'hff, T_NIL, T_FALSE, T_TRUE};
      stream_q = {stream_q, 8'hcf}; push_be('1, 8);
      stream_q = {stream_q, T_INT8, 8'h80};
      stream_q = {stream_q, 8'hd1}; push_be(64'h7fff, 2);
      stream_q = {stream_q, 8'hd2}; push_be(64'h80000000, 4);
      stream_q = {stream_q, 8'hd3}; push_be(64'h8000000000000000, 8);
      stream_q = {stream_q, 8'hcd}; push_be(64'hffff, 2);
      stream_q = {stream_q, T_F32}; push_be(64'h3f800000, 4);
      stream_q = {stream_q, T_F64}; push_be(64'hfff0000000000001, 8);
      stream_q = {stream_q, T_FIXSTR};                    // empty string
      stream_q = {stream_q, T_STR8, 8'h02, 8'h61, 8'h62};
      stream_q = {stream_q, T_BIN8, 8'h01, 8'hff};
      stream_q = {stream_q, T_FIXARR, T_FIXMAP};          // empty containers
      repeat (16) stream_q = {stream_q, (T_FIXARR | 8'd1)}; // deepest nesting
      stream_q = {stream_q, 8'h01};
      stream_q = {stream_q, T_FIXMAP | 8'd1, 8'h05, T_NEGFIX};
      stream_q = {stream_q, T_ARR16}; push_be(64'd1, 2); stream_q = {stream_q, 8'h0a};
      stream_q = {stream_q, T_MAP32}; push_be(64'd1, 4);
      stream_q = {stream_q, T_TRUE, T_NIL};
   endtask

   initial begin
      int pick;
      send_idle = 37;
      recv_idle = 63;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      build_directed();
      send_stream();
      for (int p = 0; p < 3; p++) begin
         send_idle = (p == 0) ? 37 : (p == 1) ? 63 : 0;
         recv_idle = (p == 0) ? 63 : (p == 1) ? 37 : 0;
         if (p == 2) hold_request = 1'b1;
         while (stream_q.size() < BYTES_PER_PHASE) build_value(0);
         send_stream();
      end

      // Close the run on a sticky error: open the largest counts, fill the
      // stack, then overflow it or send an unsupported code; the trailing
      // bytes must be swallowed.
      stream_q = {stream_q, T_MAP32}; push_be(64'hffffffff, 4);
      stream_q = {stream_q, T_ARR32}; push_be(64'hffffffff, 4);
      repeat (14) stream_q = {stream_q, 8'h9f};
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         stream_q = {stream_q, T_ARR32}; push_be(64'($urandom), 4);
      end else if (pick == 1) begin
         stream_q = {stream_q, (T_FIXMAP | 8'(1))};
      end else begin
         case ($urandom_range(0, 8))
            0: stream_q = {stream_q, 8'hc1};
            1: stream_q = {stream_q, 8'hc7};
            2: stream_q = {stream_q, 8'hc8};
            3: stream_q = {stream_q, 8'hc9};
            4: stream_q = {stream_q, 8'hd4};
            5: stream_q = {stream_q, 8'hd5};
            6: stream_q = {stream_q, 8'hd6};
            7: stream_q = {stream_q, 8'hd7};
            default: stream_q = {stream_q, 8'hd8};
         endcase
      end
      repeat (20) stream_q = {stream_q, 8'($urandom)};
      send_stream();
      req_tvalid <= 1'b0;

      while (tokens_pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS msgpack_stream_tokenizer");
      end else begin
         $display("FAIL msgpack_stream_tokenizer");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20000000;
      $display("FAIL msgpack_stream_tokenizer");
      $finish;
   end
endmodule
`default_nettype wire

### files.f
src/mpk_pkg.sv
src/mpk_front.sv
src/mpk_queue.sv
src/mpk_back.sv
src/msgpack_stream_tokenizer.sv
tb/mpk_token_checker.sv
tb/msgpack_stream_tokenizer_tb.sv
